@@ rtl/core/prrq_pkg.sv @@
// Shared types, field widths, operation codes and markers of the priority ready queue.
package prrq_pkg;

   localparam int SLOT_W     = 3;
   localparam int LVL_W      = 3;
   localparam int ID_W       = 6;
   localparam int ENTRY_W    = 6;
   localparam int TAIL_W     = 4;
   localparam int IDENT_W    = 7;
   localparam int OP_W       = 2;
   localparam int RING_SLOTS = 8;

   localparam logic [TAIL_W-1:0]  EMPTY_MARK = 4'd8;
   localparam logic [IDENT_W-1:0] INVALID_ID = 7'd64;

   localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_NEXT   = 2'd2;
   localparam logic [OP_W-1:0] OP_SWAP   = 2'd3;

   typedef struct packed {
      logic               wr_en;
      logic [ENTRY_W-1:0] wr_addr;
      logic [SLOT_W-1:0]  wr_data;
      logic               rd_en;
      logic [ENTRY_W-1:0] rd_addr;
   } nxt_req_type;

   typedef struct packed {
      logic               wr_en;
      logic [ENTRY_W-1:0] wr_addr;
      logic [IDENT_W-1:0] wr_data;
      logic               rd_en;
      logic [ENTRY_W-1:0] rd_addr_a;
      logic [ENTRY_W-1:0] rd_addr_b;
   } idt_req_type;

   function automatic logic [ENTRY_W-1:0] entry_of(input logic [LVL_W-1:0] lvl,
                                                   input logic [SLOT_W-1:0] slot);
      return {lvl, slot};
   endfunction

endpackage

@@ rtl/core/prrq_store.sv @@
// Next-pointer and identity memories with per-entry valid bits for reset values.
module prrq_store #(
   parameter int LEVELS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  prrq_pkg::nxt_req_type             nxt_req,
   input  prrq_pkg::idt_req_type             idt_req,
   output logic [prrq_pkg::SLOT_W-1:0]       nxt_data,
   output logic [prrq_pkg::IDENT_W-1:0]      idt_data_a,
   output logic [prrq_pkg::IDENT_W-1:0]      idt_data_b
);
   import prrq_pkg::*;

   localparam int DEPTH  = LEVELS * RING_SLOTS;
   localparam int ADDR_W = $clog2(DEPTH);

   logic [SLOT_W-1:0]  nxt_mem [DEPTH];
   logic [IDENT_W-1:0] idt_mem [DEPTH];
   logic [DEPTH-1:0]   nxt_vld_ff;
   logic [DEPTH-1:0]   idt_vld_ff;

   logic [ADDR_W-1:0]  nxt_wa, nxt_ra, idt_wa, idt_ra_a, idt_ra_b;

   logic [SLOT_W-1:0]  nxt_rd_ff;
   logic               nxt_rd_vld_ff;
   logic [SLOT_W-1:0]  nxt_rd_self_ff;
   logic [IDENT_W-1:0] idt_rd_a_ff, idt_rd_b_ff;
   logic               idt_rd_vld_a_ff, idt_rd_vld_b_ff;

   assign nxt_wa   = nxt_req.wr_addr[ADDR_W-1:0];
   assign nxt_ra   = nxt_req.rd_addr[ADDR_W-1:0];
   assign idt_wa   = idt_req.wr_addr[ADDR_W-1:0];
   assign idt_ra_a = idt_req.rd_addr_a[ADDR_W-1:0];
   assign idt_ra_b = idt_req.rd_addr_b[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (nxt_req.wr_en) begin
         nxt_mem[nxt_wa] <= nxt_req.wr_data;
      end
      if (nxt_req.rd_en) begin
         nxt_rd_ff      <= nxt_mem[nxt_ra];
         nxt_rd_vld_ff  <= nxt_vld_ff[nxt_ra];
         nxt_rd_self_ff <= nxt_ra[SLOT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (idt_req.wr_en) begin
         idt_mem[idt_wa] <= idt_req.wr_data;
      end
      if (idt_req.rd_en) begin
         idt_rd_a_ff     <= idt_mem[idt_ra_a];
         idt_rd_b_ff     <= idt_mem[idt_ra_b];
         idt_rd_vld_a_ff <= idt_vld_ff[idt_ra_a];
         idt_rd_vld_b_ff <= idt_vld_ff[idt_ra_b];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nxt_vld_ff <= '0;
         idt_vld_ff <= '0;
      end else begin
         if (nxt_req.wr_en) begin
            nxt_vld_ff[nxt_wa] <= 1'b1;
         end
         if (idt_req.wr_en) begin
            idt_vld_ff[idt_wa] <= 1'b1;
         end
      end
   end

   // An entry never written reads as its reset value.
   assign nxt_data   = nxt_rd_vld_ff ? nxt_rd_ff : nxt_rd_self_ff;
   assign idt_data_a = idt_rd_vld_a_ff ? idt_rd_a_ff : INVALID_ID;
   assign idt_data_b = idt_rd_vld_b_ff ? idt_rd_b_ff : INVALID_ID;

   a_nxt_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(nxt_req.wr_en && nxt_req.rd_en && (nxt_wa == nxt_ra)))
      else $error("next-pointer entry read and written in the same cycle");

   a_idt_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(idt_req.wr_en && idt_req.rd_en && ((idt_wa == idt_ra_a) || (idt_wa == idt_ra_b))))
      else $error("identity entry read and written in the same cycle");

   a_vld_clear_after_reset: assert property (@(posedge clock)
      $past(reset) |-> (nxt_vld_ff == '0) && (idt_vld_ff == '0))
      else $error("valid bits not cleared by reset");

endmodule

@@ rtl/core/priority_round_robin_ready_queue.sv @@
// Top level of the multilevel priority round-robin ready queue.
//
//   channel  direction  ports                                   transfer when
//   req      in         req_op, req_task_id, req_other_id       req_valid && !req_stall
//   rsp      out        rsp_chosen_task, rsp_none_ready         rsp_valid && !rsp_stall
//
// One item is in work at a time, paced by the registered memory reads. Add, next and swap
// read and then write, and stop after their first step on an empty level, empty queue or
// ignored swap; remove walks the ring link by link, at most once around it.
// Reset clears the tail pointers and the valid bits of both memories at once.
// A result waits in the output register while the next request is taken; the
// sequencer holds its finished result only when that register is still occupied.
module priority_round_robin_ready_queue #(
   parameter int NUM_LEVELS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [prrq_pkg::OP_W-1:0]       req_op,
   input  logic [prrq_pkg::ID_W-1:0]       req_task_id,
   input  logic [prrq_pkg::ID_W-1:0]       req_other_id,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [prrq_pkg::ID_W-1:0]       rsp_chosen_task,
   output logic                            rsp_none_ready
);
   import prrq_pkg::*;

   // Task ids carry only eight levels, so higher levels never hold anything.
   localparam int LIVE_LEVELS = (NUM_LEVELS < 8) ? NUM_LEVELS : 8;
   localparam int LIDX_W      = (LIVE_LEVELS > 1) ? $clog2(LIVE_LEVELS) : 1;

   localparam logic [3:0] ST_IDLE       = 4'd0;
   localparam logic [3:0] ST_ADD_HEAD   = 4'd1;
   localparam logic [3:0] ST_ADD_LINK   = 4'd2;
   localparam logic [3:0] ST_ADD_TAIL   = 4'd3;
   localparam logic [3:0] ST_REM_START  = 4'd4;
   localparam logic [3:0] ST_REM_WALK   = 4'd5;
   localparam logic [3:0] ST_REM_UNLINK = 4'd6;
   localparam logic [3:0] ST_NXT_SCAN   = 4'd7;
   localparam logic [3:0] ST_NXT_HEAD   = 4'd8;
   localparam logic [3:0] ST_NXT_IDENT  = 4'd9;
   localparam logic [3:0] ST_SWP_READ   = 4'd10;
   localparam logic [3:0] ST_SWP_WRA    = 4'd11;
   localparam logic [3:0] ST_SWP_WRB    = 4'd12;
   localparam logic [3:0] ST_RESP       = 4'd13;

   logic [3:0]         state_ff, state_in;
   logic [ID_W-1:0]    id_ff, id_in;
   logic [ID_W-1:0]    oid_ff, oid_in;
   logic [LVL_W-1:0]   lvl_ff, lvl_in;
   logic [TAIL_W-1:0]  t_ff, t_in;
   logic [SLOT_W-1:0]  pred_ff, pred_in;
   logic [SLOT_W-1:0]  cnt_ff, cnt_in;
   logic [ID_W-1:0]    res_task_ff, res_task_in;
   logic               res_none_ff, res_none_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]    rsp_task_ff, rsp_task_in;
   logic               rsp_none_ff, rsp_none_in;

   logic [TAIL_W-1:0]  tail_ff [LIVE_LEVELS];
   logic [TAIL_W-1:0]  tail_in;
   logic               tail_we;
   logic [LIDX_W-1:0]  tail_widx;

   nxt_req_type        nxt_req;
   idt_req_type        idt_req;
   logic [SLOT_W-1:0]  nxt_data;
   logic [IDENT_W-1:0] idt_data_a, idt_data_b;

   logic [LVL_W-1:0]   id_lvl, oid_lvl;
   logic [SLOT_W-1:0]  id_slot;
   logic               id_ok, oid_ok;
   logic [TAIL_W-1:0]  tail_cur;
   logic               hit;
   logic [LVL_W-1:0]   hit_lvl;
   logic [TAIL_W-1:0]  hit_tail;
   logic               req_xfer;
   logic               rsp_free;

   prrq_store #(
      .LEVELS (LIVE_LEVELS)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .nxt_req    (nxt_req),
      .idt_req    (idt_req),
      .nxt_data   (nxt_data),
      .idt_data_a (idt_data_a),
      .idt_data_b (idt_data_b)
   );

   assign id_lvl   = id_ff[ID_W-1:SLOT_W];
   assign oid_lvl  = oid_ff[ID_W-1:SLOT_W];
   assign id_slot  = id_ff[SLOT_W-1:0];
   assign id_ok    = int'(id_lvl) < LIVE_LEVELS;
   assign oid_ok   = int'(oid_lvl) < LIVE_LEVELS;
   assign tail_cur = tail_ff[id_lvl[LIDX_W-1:0]];

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      hit      = 1'b0;
      hit_lvl  = '0;
      hit_tail = EMPTY_MARK;
      for (int i = LIVE_LEVELS - 1; i >= 0; i--) begin
         if (tail_ff[i] != EMPTY_MARK) begin
            hit      = 1'b1;
            hit_lvl  = LVL_W'(i);
            hit_tail = tail_ff[i];
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      id_in        = id_ff;
      oid_in       = oid_ff;
      lvl_in       = lvl_ff;
      t_in         = t_ff;
      pred_in      = pred_ff;
      cnt_in       = cnt_ff;
      res_task_in  = res_task_ff;
      res_none_in  = res_none_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_task_in  = rsp_task_ff;
      rsp_none_in  = rsp_none_ff;
      tail_we      = 1'b0;
      tail_widx    = id_lvl[LIDX_W-1:0];
      tail_in      = EMPTY_MARK;
      nxt_req      = '0;
      idt_req      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               id_in       = req_task_id;
               oid_in      = req_other_id;
               res_task_in = '0;
               res_none_in = 1'b0;
               unique case (req_op)
                  OP_ADD:    state_in = ST_ADD_HEAD;
                  OP_REMOVE: state_in = ST_REM_START;
                  OP_NEXT:   state_in = ST_NXT_SCAN;
                  OP_SWAP:   state_in = ST_SWP_READ;
                  default:   state_in = ST_RESP;
               endcase
            end
         end
         ST_ADD_HEAD: begin
            state_in = ST_RESP;
            if (id_ok) begin
               idt_req.wr_en   = 1'b1;
               idt_req.wr_addr = id_ff;
               idt_req.wr_data = {1'b0, id_ff};
               t_in            = tail_cur;
               if (tail_cur == EMPTY_MARK) begin
                  nxt_req.wr_en   = 1'b1;
                  nxt_req.wr_addr = id_ff;
                  nxt_req.wr_data = id_slot;
                  tail_we         = 1'b1;
                  tail_in         = {1'b0, id_slot};
               end else begin
                  nxt_req.rd_en   = 1'b1;
                  nxt_req.rd_addr = entry_of(id_lvl, tail_cur[SLOT_W-1:0]);
                  state_in        = ST_ADD_LINK;
               end
            end
         end
         ST_ADD_LINK: begin
            nxt_req.wr_en   = 1'b1;
            nxt_req.wr_addr = id_ff;
            nxt_req.wr_data = nxt_data;
            state_in        = ST_ADD_TAIL;
         end
         ST_ADD_TAIL: begin
            nxt_req.wr_en   = 1'b1;
            nxt_req.wr_addr = entry_of(id_lvl, t_ff[SLOT_W-1:0]);
            nxt_req.wr_data = id_slot;
            tail_we         = 1'b1;
            tail_in         = {1'b0, id_slot};
            state_in        = ST_RESP;
         end
         ST_REM_START: begin
            state_in = ST_RESP;
            if (id_ok && (tail_cur != EMPTY_MARK)) begin
               t_in            = tail_cur;
               pred_in         = tail_cur[SLOT_W-1:0];
               cnt_in          = '0;
               nxt_req.rd_en   = 1'b1;
               nxt_req.rd_addr = entry_of(id_lvl, tail_cur[SLOT_W-1:0]);
               state_in        = ST_REM_WALK;
            end
         end
         ST_REM_WALK: begin
            if ((cnt_ff == '0) && (nxt_data == t_ff[SLOT_W-1:0])) begin
               // Single-member ring: empty it only when that member is named.
               state_in = ST_RESP;
               if (t_ff[SLOT_W-1:0] == id_slot) begin
                  tail_we         = 1'b1;
                  tail_in         = EMPTY_MARK;
                  idt_req.wr_en   = 1'b1;
                  idt_req.wr_addr = id_ff;
                  idt_req.wr_data = INVALID_ID;
               end
            end else if (nxt_data == id_slot) begin
               nxt_req.rd_en   = 1'b1;
               nxt_req.rd_addr = id_ff;
               state_in        = ST_REM_UNLINK;
            end else if (cnt_ff == SLOT_W'(RING_SLOTS - 1)) begin
               state_in = ST_RESP;
            end else begin
               pred_in         = nxt_data;
               cnt_in          = cnt_ff + 1'b1;
               nxt_req.rd_en   = 1'b1;
               nxt_req.rd_addr = entry_of(id_lvl, nxt_data);
            end
         end
         ST_REM_UNLINK: begin
            nxt_req.wr_en   = 1'b1;
            nxt_req.wr_addr = entry_of(id_lvl, pred_ff);
            nxt_req.wr_data = nxt_data;
            idt_req.wr_en   = 1'b1;
            idt_req.wr_addr = id_ff;
            idt_req.wr_data = INVALID_ID;
            if (t_ff[SLOT_W-1:0] == id_slot) begin
               tail_we = 1'b1;
               tail_in = {1'b0, pred_ff};
            end
            state_in = ST_RESP;
         end
         ST_NXT_SCAN: begin
            if (hit) begin
               lvl_in          = hit_lvl;
               nxt_req.rd_en   = 1'b1;
               nxt_req.rd_addr = entry_of(hit_lvl, hit_tail[SLOT_W-1:0]);
               state_in        = ST_NXT_HEAD;
            end else begin
               res_none_in = 1'b1;
               state_in    = ST_RESP;
            end
         end
         ST_NXT_HEAD: begin
            tail_we           = 1'b1;
            tail_widx         = lvl_ff[LIDX_W-1:0];
            tail_in           = {1'b0, nxt_data};
            idt_req.rd_en     = 1'b1;
            idt_req.rd_addr_a = entry_of(lvl_ff, nxt_data);
            idt_req.rd_addr_b = entry_of(lvl_ff, nxt_data);
            state_in          = ST_NXT_IDENT;
         end
         ST_NXT_IDENT: begin
            if (idt_data_a[IDENT_W-1]) begin
               res_none_in = 1'b1;
               res_task_in = '0;
            end else begin
               res_none_in = 1'b0;
               res_task_in = idt_data_a[ID_W-1:0];
            end
            state_in = ST_RESP;
         end
         ST_SWP_READ: begin
            state_in = ST_RESP;
            if ((id_ff != oid_ff) && id_ok && oid_ok) begin
               idt_req.rd_en     = 1'b1;
               idt_req.rd_addr_a = id_ff;
               idt_req.rd_addr_b = oid_ff;
               state_in          = ST_SWP_WRA;
            end
         end
         ST_SWP_WRA: begin
            idt_req.wr_en   = 1'b1;
            idt_req.wr_addr = id_ff;
            idt_req.wr_data = idt_data_b;
            state_in        = ST_SWP_WRB;
         end
         ST_SWP_WRB: begin
            idt_req.wr_en   = 1'b1;
            idt_req.wr_addr = oid_ff;
            idt_req.wr_data = idt_data_a;
            state_in        = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_task_in  = res_task_ff;
               rsp_none_in  = res_none_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff       <= id_in;
      oid_ff      <= oid_in;
      lvl_ff      <= lvl_in;
      t_ff        <= t_in;
      pred_ff     <= pred_in;
      cnt_ff      <= cnt_in;
      res_task_ff <= res_task_in;
      res_none_ff <= res_none_in;
      rsp_task_ff <= rsp_task_in;
      rsp_none_ff <= rsp_none_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LIVE_LEVELS; i++) begin
            tail_ff[i] <= EMPTY_MARK;
         end
      end else if (tail_we) begin
         tail_ff[tail_widx] <= tail_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_chosen_task = rsp_task_ff;
   assign rsp_none_ready  = rsp_none_ff;

   a_none_means_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_none_ff) |-> (rsp_task_ff == '0))
      else $error("none_ready result carries a nonzero task");

   a_xfer_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff != ST_IDLE))
      else $error("request transfer did not start the sequencer");

   a_resp_loads_output: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_RESP) && rsp_free) |=> rsp_valid_ff)
      else $error("finished result not loaded into the output register");

endmodule

@@ tb/sv/priority_round_robin_ready_queue_tb.sv @@
// Self-checking testbench for the priority round-robin ready queue with a built-in predictor.
module priority_round_robin_ready_queue_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import prrq_pkg::*;

   localparam int NUM_LEVELS  = 8;
   localparam int CYCLE_LIMIT = 500000;

   typedef struct packed {
      logic [ID_W-1:0] chosen_task;
      logic            none_ready;
   } pick_result_type;

   typedef enum {STALL_NONE, STALL_RANDOM, STALL_PATTERN} stall_mode_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   logic [OP_W-1:0] req_op = OP_ADD;
   logic [ID_W-1:0] req_task_id = '0;
   logic [ID_W-1:0] req_other_id = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   logic [ID_W-1:0] rsp_chosen_task;
   logic            rsp_none_ready;

   logic [SLOT_W-1:0]  ring_next [NUM_LEVELS*RING_SLOTS];
   logic [TAIL_W-1:0]  level_tail [NUM_LEVELS];
   logic [IDENT_W-1:0] slot_ident [NUM_LEVELS*RING_SLOTS];

   pick_result_type expected_picks [$];
   pick_result_type want;
   int             errors = 0;
   int             cycle_count = 0;
   stall_mode_type stall_mode = STALL_NONE;
   logic [7:0]     stall_pattern = 8'h00;
   logic [7:0]     stall_phase = 8'h00;
   int             hold_request = 0;
   int             hold_left = 0;

   priority_round_robin_ready_queue #(
      .NUM_LEVELS(NUM_LEVELS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_op(req_op),
      .req_task_id(req_task_id),
      .req_other_id(req_other_id),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_chosen_task(rsp_chosen_task),
      .rsp_none_ready(rsp_none_ready)
   );

   always #1 clock = ~clock;

   function automatic void queue_clear();
      for (int e = 0; e < NUM_LEVELS*RING_SLOTS; e++) begin
         ring_next[e]  = SLOT_W'(e);
         slot_ident[e] = INVALID_ID;
      end
      for (int l = 0; l < NUM_LEVELS; l++) begin
         level_tail[l] = EMPTY_MARK;
      end
   endfunction

   function automatic pick_result_type sched_apply(input logic [OP_W-1:0] op,
                                                   input logic [ID_W-1:0] id,
                                                   input logic [ID_W-1:0] other);
      pick_result_type   r;
      logic [LVL_W-1:0]  lvl;
      logic [LVL_W-1:0]  lv;
      logic [SLOT_W-1:0] slot;
      logic [SLOT_W-1:0] pred;
      logic [SLOT_W-1:0] head;
      logic [SLOT_W-1:0] ts;
      logic [TAIL_W-1:0] t;
      logic [IDENT_W-1:0] held;
      bit                found;
      bit                done;
      r.chosen_task = '0;
      r.none_ready  = 1'b0;
      lvl  = id[ID_W-1:SLOT_W];
      slot = id[SLOT_W-1:0];
      t    = level_tail[lvl];
      ts   = t[SLOT_W-1:0];
      case (op)
         OP_ADD: begin
            if (int'(lvl) < NUM_LEVELS) begin
               slot_ident[{lvl, slot}] = {1'b0, id};
               if (t == EMPTY_MARK) begin
                  ring_next[{lvl, slot}] = slot;
               end else begin
                  ring_next[{lvl, slot}] = ring_next[{lvl, ts}];
                  ring_next[{lvl, ts}]   = slot;
               end
               level_tail[lvl] = {1'b0, slot};
            end
         end
         OP_REMOVE: begin
            if (int'(lvl) < NUM_LEVELS && t != EMPTY_MARK) begin
               if (ring_next[{lvl, ts}] == ts) begin
                  if (ts == slot) begin
                     level_tail[lvl] = EMPTY_MARK;
                     slot_ident[{lvl, slot}] = INVALID_ID;
                  end
               end else begin
                  pred  = ts;
                  found = 1'b0;
                  for (int i = 0; i < RING_SLOTS && !found; i++) begin
                     if (ring_next[{lvl, pred}] == slot) found = 1'b1;
                     else pred = ring_next[{lvl, pred}];
                  end
                  if (found) begin
                     ring_next[{lvl, pred}] = ring_next[{lvl, slot}];
                     if (ts == slot) level_tail[lvl] = {1'b0, pred};
                     slot_ident[{lvl, slot}] = INVALID_ID;
                  end
               end
            end
         end
         OP_NEXT: begin
            r.none_ready = 1'b1;
            done = 1'b0;
            for (int l = 0; l < NUM_LEVELS && !done; l++) begin
               if (level_tail[l] != EMPTY_MARK) begin
                  lv   = LVL_W'(l);
                  head = ring_next[{lv, level_tail[l][SLOT_W-1:0]}];
                  level_tail[l] = {1'b0, head};
                  if (!slot_ident[{lv, head}][IDENT_W-1]) begin
                     r.chosen_task = slot_ident[{lv, head}][ID_W-1:0];
                     r.none_ready  = 1'b0;
                  end
                  done = 1'b1;
               end
            end
         end
         default: begin
            if (id != other && int'(lvl) < NUM_LEVELS &&
                int'(other[ID_W-1:SLOT_W]) < NUM_LEVELS) begin
               held              = slot_ident[id];
               slot_ident[id]    = slot_ident[other];
               slot_ident[other] = held;
            end
         end
      endcase
      return r;
   endfunction

   task automatic send_item(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                            input logic [ID_W-1:0] other);
      @(negedge clock);
      req_valid    = 1'b1;
      req_op       = op;
      req_task_id  = id;
      req_other_id = other;
      do @(posedge clock); while (req_stall);
      expected_picks.push_back(sched_apply(op, id, other));
   endtask

   task automatic sender_pause(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid    = 1'b0;
         req_op       = OP_W'($urandom);
         req_task_id  = ID_W'($urandom);
         req_other_id = ID_W'($urandom);
      end
   endtask

   task automatic test_empty_queue();
      send_item(OP_NEXT, 6'd0, 6'd0);
      send_item(OP_REMOVE, 6'd0, 6'd0);
      send_item(OP_SWAP, 6'd0, 6'd63);
      send_item(OP_SWAP, 6'd21, 6'd21);
   endtask

   task automatic test_single_slot();
      send_item(OP_ADD, 6'd9, 6'd0);
      send_item(OP_REMOVE, 6'd10, 6'd0);
      send_item(OP_NEXT, 6'd0, 6'd0);
      send_item(OP_REMOVE, 6'd9, 6'd0);
      send_item(OP_NEXT, 6'd0, 6'd0);
   endtask

   task automatic test_ring_order();
      send_item(OP_ADD, 6'd63, 6'd0);
      send_item(OP_ADD, 6'd56, 6'd0);
      send_item(OP_ADD, 6'd60, 6'd0);
      send_item(OP_NEXT, 6'd0, 6'd0);
      send_item(OP_REMOVE, 6'd56, 6'd0);
      send_item(OP_REMOVE, 6'd57, 6'd0);
      send_item(OP_NEXT, 6'd0, 6'd0);
      send_item(OP_ADD, 6'd60, 6'd0);
      send_item(OP_NEXT, 6'd0, 6'd0);
      send_item(OP_ADD, 6'd0, 6'd0);
   endtask

   task automatic test_identity_swap();
      send_item(OP_SWAP, 6'd0, 6'd62);
      send_item(OP_NEXT, 6'd0, 6'd0);
      send_item(OP_SWAP, 6'd62, 6'd0);
      send_item(OP_NEXT, 6'd0, 6'd0);
      send_item(OP_REMOVE, 6'd0, 6'd0);
      send_item(OP_NEXT, 6'd0, 6'd0);
   endtask

   // The receiver holds off while the sender keeps offering, so the input backs up.
   task automatic test_output_hold_off();
      stall_mode   = STALL_NONE;
      hold_request = 400;
      repeat (40) begin
         send_item(OP_W'($urandom), ID_W'($urandom_range(0, 23)), ID_W'($urandom));
      end
   endtask

   task automatic test_random_phase(input int count, input int lvl_lo, input int lvl_hi,
                                    input int gap_max, input stall_mode_type mode);
      logic [OP_W-1:0] op;
      logic [ID_W-1:0] id;
      logic [ID_W-1:0] other;
      logic [ID_W-1:0] recent [$];
      int              r;
      int              burst_left;
      stall_mode    = mode;
      stall_pattern = 8'($urandom) & 8'h7f;
      burst_left    = 0;
      repeat (count) begin
         if (burst_left == 0) begin
            if (gap_max > 0) sender_pause($urandom_range(1, gap_max));
            burst_left = $urandom_range(1, 16);
         end
         r = $urandom_range(0, 99);
         if (r < 10) begin
            op    = OP_W'($urandom);
            id    = ID_W'($urandom);
            other = ID_W'($urandom);
         end else begin
            id = {LVL_W'($urandom_range(lvl_lo, lvl_hi)), SLOT_W'($urandom)};
            if (recent.size() != 0 && $urandom_range(0, 1) == 1)
               other = recent[$urandom_range(0, recent.size() - 1)];
            else
               other = ID_W'($urandom);
            if (r < 45) begin
               op = OP_ADD;
            end else if (r < 65) begin
               op = OP_REMOVE;
               if (recent.size() != 0 && $urandom_range(0, 3) != 0)
                  id = recent[$urandom_range(0, recent.size() - 1)];
            end else if (r < 92) begin
               op = OP_NEXT;
            end else begin
               op = OP_SWAP;
            end
         end
         if (op == OP_ADD) begin
            recent.push_back(id);
            if (recent.size() > 24) void'(recent.pop_front());
         end
         send_item(op, id, other);
         burst_left--;
      end
   endtask

   task automatic test_random();
      test_random_phase(300, 0, 1, 0, STALL_NONE);
      test_random_phase(300, 0, 7, 8, STALL_RANDOM);
      test_random_phase(300, 5, 7, 3, STALL_PATTERN);
      test_random_phase(250, 0, 3, 12, STALL_RANDOM);
      test_random_phase(250, 7, 7, 0, STALL_PATTERN);
      test_random_phase(250, 0, 7, 5, STALL_NONE);
   endtask

   always @(negedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      stall_phase = stall_phase + 8'd1;
      if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_stall = 1'b1;
      end else begin
         case (stall_mode)
            STALL_RANDOM:  rsp_stall = ($urandom_range(0, 99) < 35);
            STALL_PATTERN: rsp_stall = stall_pattern[stall_phase[2:0]];
            default:       rsp_stall = 1'b0;
         endcase
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_picks.size() == 0) begin
            $display("%0t: result transfer with none expected: chosen_task=%0d none_ready=%0b",
                     $time, rsp_chosen_task, rsp_none_ready);
            errors++;
         end else begin
            want = expected_picks.pop_front();
            if (rsp_chosen_task !== want.chosen_task) begin
               $display("%0t: chosen_task expected %0d actual %0d",
                        $time, want.chosen_task, rsp_chosen_task);
               errors++;
            end
            if (rsp_none_ready !== want.none_ready) begin
               $display("%0t: none_ready expected %0b actual %0b",
                        $time, want.none_ready, rsp_none_ready);
               errors++;
            end
         end
      end
   end

   initial begin
      queue_clear();
      repeat (6) @(negedge clock);
      reset = 1'b0;
      test_empty_queue();
      test_single_slot();
      test_ring_order();
      test_identity_swap();
      test_output_hold_off();
      test_random();
      sender_pause(1);
      while (expected_picks.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
